>>> design/checksummed_frame_receiver_macros.svh
// assertion macros for the checksummed frame receiver
// used by the top level; expects a clock named clk and a reset named rst in scope
`ifndef CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH
`define CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cfr_pkg.sv
// shared constants, types and helpers for the checksummed frame receiver
// no dependencies; imported by cfr_frame_tracker and the top level
`timescale 1ns / 1ps

package cfr_pkg;

  // frame geometry: start byte at position 0, checksum at FRAME_BYTES
  localparam int FRAME_BYTES = 64;
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);
  localparam int BYTE_POS_W  = 7;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 32;

  typedef logic [POS_W-1:0]   fill_pos_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;

  // one result transaction
  typedef struct packed {
    logic                  byte_taken;
    logic [BYTE_POS_W-1:0] byte_position;
    byte_t                 byte_value;
    logic                  frame_end;
    logic                  frame_good;
    count_t                good_frames;
    count_t                bad_frames;
  } cfr_result_t;

  // reported position is the fill position modulo 128
  function automatic logic [BYTE_POS_W-1:0] to_byte_pos(input fill_pos_t pos);
    logic [POS_W+BYTE_POS_W-1:0] wide;
    wide = {{BYTE_POS_W{1'b0}}, pos};
    return wide[BYTE_POS_W-1:0];
  endfunction

endpackage

>>> design/cfr_frame_tracker.sv
// frame tracking state: fill position, running checksum and frame counters
// depends on cfr_pkg; builds the result for the byte presented this cycle
`timescale 1ns / 1ps

module cfr_frame_tracker import cfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  byte_t       rx_byte,
  input  byte_t       start_marker,
  output cfr_result_t result
);

  localparam fill_pos_t FRAME_LAST = POS_W'(FRAME_BYTES);
  localparam fill_pos_t FIRST_DATA = POS_W'(1);

  fill_pos_t fill_position;
  fill_pos_t fill_position_next;
  byte_t     running_sum;
  byte_t     running_sum_next;
  count_t    good_count;
  count_t    good_count_next;
  count_t    bad_count;
  count_t    bad_count_next;

  logic idle;
  logic taken;
  logic at_end;
  logic sum_match;

  // byte classification
  assign idle      = (fill_position == '0);
  assign taken     = !idle || (rx_byte == start_marker);
  assign at_end    = (fill_position == FRAME_LAST);
  assign sum_match = (running_sum == rx_byte);

  // next state for the byte on the input
  always_comb begin
    fill_position_next = fill_position;
    running_sum_next   = running_sum;
    good_count_next    = good_count;
    bad_count_next     = bad_count;
    if (taken) begin
      if (idle) begin
        fill_position_next = FIRST_DATA;
        running_sum_next   = '0;
      end else if (!at_end) begin
        fill_position_next = fill_position + FIRST_DATA;
        running_sum_next   = running_sum + rx_byte;
      end else begin
        fill_position_next = '0;
        running_sum_next   = '0;
        if (sum_match) begin
          good_count_next = good_count + COUNT_W'(1);
        end else begin
          bad_count_next = bad_count + COUNT_W'(1);
        end
      end
    end
  end

  // result fields, counters reported after this byte
  always_comb begin
    result.byte_taken    = taken;
    result.byte_position = taken ? to_byte_pos(fill_position) : '0;
    result.byte_value    = taken ? rx_byte : '0;
    result.frame_end     = taken && at_end;
    result.frame_good    = taken && at_end && sum_match;
    result.good_frames   = good_count_next;
    result.bad_frames    = bad_count_next;
  end

  // state registers, advanced once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_position <= '0;
      running_sum   <= '0;
      good_count    <= '0;
      bad_count     <= '0;
    end else if (step) begin
      fill_position <= fill_position_next;
      running_sum   <= running_sum_next;
      good_count    <= good_count_next;
      bad_count     <= bad_count_next;
    end
  end

endmodule

>>> design/checksummed_frame_receiver.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | rx_byte
// out     | output    | out_valid / out_stall | byte_taken .. bad_frames
// cfg     | input     | cfg_valid / cfg_ready | start_marker
//
// one byte per cycle while in_stall is low; each byte that is taken yields one result
// results are registered in the output register behind the tracker logic
// a skid register holds one extra result, so in_stall rises only once two are waiting
// rst is synchronous: idle, empty checksum, zero counters, start marker zero
// depends on cfr_pkg, cfr_frame_tracker and checksummed_frame_receiver_macros.svh
`timescale 1ns / 1ps
`include "checksummed_frame_receiver_macros.svh"

module checksummed_frame_receiver import cfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // byte input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  byte_t                 rx_byte,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  byte_taken,
  output logic [BYTE_POS_W-1:0] byte_position,
  output byte_t                 byte_value,
  output logic                  frame_end,
  output logic                  frame_good,
  output count_t                good_frames,
  output count_t                bad_frames,
  // start marker register write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  byte_t                 start_marker
);

  byte_t       marker;
  cfr_result_t result;
  cfr_result_t out_reg;
  cfr_result_t skid_reg;
  logic        skid_valid;
  logic        in_accept;
  logic        out_take;
  logic        out_free;

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign out_free  = !out_valid || !out_stall;

  // start marker register
  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= '0;
    end else if (cfg_valid && cfg_ready) begin
      marker <= start_marker;
    end
  end

  // frame state and result logic
  cfr_frame_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .step         (in_accept),
    .rx_byte      (rx_byte),
    .start_marker (marker),
    .result       (result)
  );

  // output and skid valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid && out_take) begin
      skid_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (out_free) begin
        out_reg <= result;
      end else begin
        skid_reg <= result;
      end
    end else if (skid_valid && out_take) begin
      out_reg <= skid_reg;
    end
  end

  // result ports
  assign byte_taken    = out_reg.byte_taken;
  assign byte_position = out_reg.byte_position;
  assign byte_value    = out_reg.byte_value;
  assign frame_end     = out_reg.frame_end;
  assign frame_good    = out_reg.frame_good;
  assign good_frames   = out_reg.good_frames;
  assign bad_frames    = out_reg.bad_frames;

  // checks
  `CFR_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
                  "skid holds a result while output is empty")
  `CFR_ASSERT_NEXT(a_stalled_accept_to_skid, in_accept && out_valid && out_stall,
                   skid_valid, "stalled transaction not parked in skid")
  `CFR_ASSERT_NOW(a_good_needs_end, out_valid && frame_good,
                  frame_end && byte_taken, "frame_good without a closing byte")

endmodule
